// ===== sv/prescaled_compare_timer_bank_core_macros.svh =====
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_COMPARE_TIMER_BANK_CORE_MACROS_SVH
`define PRESCALED_COMPARE_TIMER_BANK_CORE_MACROS_SVH

// Same-cycle implication
`define PCTB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PCTB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pctb_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Sizes, request codes, compare modes and the per-timer record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pctb_pkg;

   localparam int NUM_TIMERS   = 16;
   localparam int RESULT_LIMIT = 16;

   // Field widths
   localparam int VAL_W  = 32;
   localparam int INT_W  = 16;
   localparam int ID_W   = 16;
   localparam int TIDX_W = 4;
   localparam int MODE_W = 2;
   localparam int CFG_W  = 5;

   // Derived sizes
   localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
   localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int SEL_W   = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;
   localparam int FIRE_W  = $clog2(RESULT_LIMIT + 1);

   // Request codes
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Compare modes
   localparam logic [MODE_W-1:0] CMP_EQ = 2'd0;
   localparam logic [MODE_W-1:0] CMP_GE = 2'd1;
   localparam logic [MODE_W-1:0] CMP_LE = 2'd2;

   // One timer's full state
   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [INT_W-1:0]  countdown;
      logic [INT_W-1:0]  interval;
      logic [INT_W-1:0]  step;
      logic              dir_down;
      logic [MODE_W-1:0] mode;
      logic [VAL_W-1:0]  threshold;
      logic              run;
      logic [ID_W-1:0]   action;
      logic [ID_W-1:0]   owner;
   } timer_rec_type;

   // Per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== sv/pctb_cell.sv =====
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer record; loads it directly or takes its neighbor's record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  pctb_pkg::cell_ctrl_type ctrl,
   input  pctb_pkg::timer_rec_type load_rec,
   input  pctb_pkg::timer_rec_type shift_in,
   output pctb_pkg::timer_rec_type rec_out
);
   import pctb_pkg::*;

   timer_rec_type rec_ff;
   timer_rec_type rec_in;

   // Next record: load wins, otherwise take the neighbor's record
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.load) begin
         rec_in = load_rec;
      end else if (ctrl.shift) begin
         rec_in = shift_in;
      end
   end

   // Run flag and value are cleared by reset; settings carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.run   <= 1'b0;
         rec_ff.value <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

// ===== sv/pctb_update.sv =====
// ----------------------------------------------------------------------------
// Timer update unit
// Counts down the head record, steps its value and checks the compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctb_update (
   input  logic                    active,
   input  pctb_pkg::timer_rec_type rec_in,
   output pctb_pkg::timer_rec_type rec_out,
   output logic                    fire
);
   import pctb_pkg::*;

   logic [INT_W-1:0] cd_dec;
   logic [VAL_W-1:0] step_ext;
   logic             live;
   logic             hit;

   assign live     = active && rec_in.run;
   assign cd_dec   = rec_in.countdown - INT_W'(1);
   assign step_ext = VAL_W'(rec_in.step);

   // Countdown and value step
   always_comb begin
      rec_out = rec_in;
      if (live) begin
         rec_out.countdown = cd_dec;
         if (cd_dec == '0) begin
            rec_out.countdown = rec_in.interval;
            if (rec_in.dir_down) begin
               rec_out.value = rec_in.value - step_ext;
            end else begin
               rec_out.value = rec_in.value + step_ext;
            end
         end
      end
   end

   // Signed compare against threshold
   always_comb begin
      unique case (rec_in.mode)
         CMP_EQ:  hit = (rec_out.value == rec_in.threshold);
         CMP_GE:  hit = ($signed(rec_out.value) >= $signed(rec_in.threshold));
         CMP_LE:  hit = ($signed(rec_out.value) <= $signed(rec_in.threshold));
         default: hit = 1'b0;
      endcase
   end

   assign fire = live && hit;

endmodule

// ===== sv/prescaled_compare_timer_bank_core.sv =====
// Tick: the scan visits each timer slot (NUM_TIMERS) in ST_SCAN, then ST_FINISH closes it;
// the final result is registered in ST_FINISH, and busy holds off a new request until idle.
// Fire results leave one per cycle at most, as the record ring rotates past the head.
// Load: no result, busy stays low.
// Reset: all timers stopped, values zero, timers_in_use zero; receiver cannot stall.
// ----------------------------------------------------------------------------
// Prescaled compare timer bank
// Ring of timer cells rotated through one shared update unit per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prescaled_compare_timer_bank_core_macros.svh"

module prescaled_compare_timer_bank_core (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [pctb_pkg::TIDX_W-1:0]        req_timer_index,
   input  logic signed [pctb_pkg::VAL_W-1:0]  req_start_value,
   input  logic [pctb_pkg::INT_W-1:0]         req_reload_interval,
   input  logic [pctb_pkg::INT_W-1:0]         req_step_size,
   input  logic                               req_count_down,
   input  logic [pctb_pkg::MODE_W-1:0]        req_compare_mode,
   input  logic signed [pctb_pkg::VAL_W-1:0]  req_threshold,
   input  logic                               req_run,
   input  logic [pctb_pkg::ID_W-1:0]          req_action_id,
   input  logic [pctb_pkg::ID_W-1:0]          req_owner_id,
   // Result channel
   output logic                               rsp_valid,
   output logic                               rsp_fired,
   output logic [pctb_pkg::TIDX_W-1:0]        rsp_fired_index,
   output logic [pctb_pkg::ID_W-1:0]          rsp_fired_action,
   output logic [pctb_pkg::ID_W-1:0]          rsp_fired_owner,
   output logic signed [pctb_pkg::VAL_W-1:0]  rsp_current_value,
   output logic                               rsp_last,
   // Configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pctb_pkg::CFG_W-1:0]         csr_data
);
   import pctb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [FIRE_W-1:0]  fire_cnt_ff;
   logic [CFG_W-1:0]   in_use_ff;

   // Held fire result, released when the next one arrives or at the end
   logic               pend_valid_ff;
   logic [TIDX_W-1:0]  pend_index_ff;
   logic [ID_W-1:0]    pend_action_ff;
   logic [ID_W-1:0]    pend_owner_ff;
   logic [VAL_W-1:0]   pend_value_ff;

   // Output registers
   logic               rsp_valid_ff;
   logic               rsp_fired_ff;
   logic [TIDX_W-1:0]  rsp_index_ff;
   logic [ID_W-1:0]    rsp_action_ff;
   logic [ID_W-1:0]    rsp_owner_ff;
   logic [VAL_W-1:0]   rsp_value_ff;
   logic               rsp_last_ff;

   logic               req_acc;
   logic               load_acc;
   logic               tick_acc;
   logic               scanning;
   logic [LIM_W-1:0]   in_use_ext;
   logic [LIM_W-1:0]   limit;
   logic               active;
   logic               upd_fire;
   logic               take_fire;

   timer_rec_type      load_rec;
   timer_rec_type      upd_rec;
   timer_rec_type      chain [NUM_TIMERS+1];
   cell_ctrl_type      cell_ctrl [NUM_TIMERS];

   // Handshakes
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = start && !busy;
   assign load_acc  = req_acc && (req_type == REQ_LOAD);
   assign tick_acc  = req_acc && (req_type == REQ_TICK);
   assign scanning  = (state_ff == ST_SCAN);

   // Effective slot count, saturated to the bank size
   assign in_use_ext = LIM_W'(in_use_ff);
   assign limit      = (in_use_ext > LIM_W'(NUM_TIMERS)) ? LIM_W'(NUM_TIMERS) : in_use_ext;
   assign active     = scanning && (LIM_W'(slot_ff) < limit);

   // Record written by a load
   always_comb begin
      load_rec.value     = $unsigned(req_start_value);
      load_rec.countdown = req_reload_interval;
      load_rec.interval  = req_reload_interval;
      load_rec.step      = req_step_size;
      load_rec.dir_down  = req_count_down;
      load_rec.mode      = req_compare_mode;
      load_rec.threshold = $unsigned(req_threshold);
      load_rec.run       = req_run;
      load_rec.action    = req_action_id;
      load_rec.owner     = req_owner_id;
   end

   // Ring of cells: head is cell 0, updated record re-enters at the tail
   genvar gi;
   generate
      for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
         always_comb begin
            cell_ctrl[gi].shift = scanning;
            cell_ctrl[gi].load  = load_acc && (SEL_W'(req_timer_index) == SEL_W'(gi));
         end

         pctb_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (cell_ctrl[gi]),
            .load_rec (load_rec),
            .shift_in (chain[gi+1]),
            .rec_out  (chain[gi])
         );
      end
   endgenerate

   assign chain[NUM_TIMERS] = upd_rec;

   pctb_update u_update (
      .active  (active),
      .rec_in  (chain[0]),
      .rec_out (upd_rec),
      .fire    (upd_fire)
   );

   assign take_fire = upd_fire && (fire_cnt_ff < FIRE_W'(RESULT_LIMIT));

   // Sequencer, result collection and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         fire_cnt_ff   <= '0;
         in_use_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            in_use_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (tick_acc) begin
                  state_ff      <= ST_SCAN;
                  slot_ff       <= '0;
                  fire_cnt_ff   <= '0;
                  pend_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               // Release the held fire, keep the new one
               rsp_valid_ff <= take_fire && pend_valid_ff;
               if (take_fire) begin
                  rsp_fired_ff   <= 1'b1;
                  rsp_index_ff   <= pend_index_ff;
                  rsp_action_ff  <= pend_action_ff;
                  rsp_owner_ff   <= pend_owner_ff;
                  rsp_value_ff   <= pend_value_ff;
                  rsp_last_ff    <= 1'b0;
                  pend_valid_ff  <= 1'b1;
                  pend_index_ff  <= TIDX_W'(slot_ff);
                  pend_action_ff <= chain[0].action;
                  pend_owner_ff  <= chain[0].owner;
                  pend_value_ff  <= upd_rec.value;
                  fire_cnt_ff    <= fire_cnt_ff + FIRE_W'(1);
               end
               if (slot_ff == IDX_W'(NUM_TIMERS - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  slot_ff <= slot_ff + IDX_W'(1);
               end
            end
            ST_FINISH: begin
               // Final result: held fire, or the single non-fired result
               rsp_valid_ff  <= 1'b1;
               rsp_fired_ff  <= pend_valid_ff;
               rsp_index_ff  <= pend_valid_ff ? pend_index_ff : '0;
               rsp_action_ff <= pend_valid_ff ? pend_action_ff : '0;
               rsp_owner_ff  <= pend_valid_ff ? pend_owner_ff : '0;
               rsp_value_ff  <= pend_valid_ff ? pend_value_ff : '0;
               rsp_last_ff   <= 1'b1;
               pend_valid_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_index   = rsp_index_ff;
   assign rsp_fired_action  = rsp_action_ff;
   assign rsp_fired_owner   = rsp_owner_ff;
   assign rsp_current_value = $signed(rsp_value_ff);
   assign rsp_last          = rsp_last_ff;

   // Checks
   `PCTB_ASSERT_NEXT(a_finish_last, state_ff == ST_FINISH, rsp_valid && rsp_last, "no last")
   `PCTB_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_last, !rsp_valid, "result after last")
   `PCTB_ASSERT_NOW(a_nonfire_is_last, rsp_valid && !rsp_fired, rsp_last, "non-fired not last")
   `PCTB_ASSERT_NEXT(a_tick_sets_busy, tick_acc, busy && slot_ff == '0, "tick did not scan")
   `PCTB_ASSERT_NOW(a_fire_limit, 1'b1, fire_cnt_ff <= FIRE_W'(RESULT_LIMIT), "fires past limit")

endmodule

// ===== tb/timer_bank_checker.sv =====
// ----------------------------------------------------------------------------
// Timer bank checker
// Watches the request, result and register channels, keeps its own copy of
// the timer bank, predicts the results of every tick and compares them in
// order against what the bank reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_bank_checker (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_type,
   input  logic [pctb_pkg::TIDX_W-1:0]        req_timer_index,
   input  logic [pctb_pkg::VAL_W-1:0]         req_start_value,
   input  logic [pctb_pkg::INT_W-1:0]         req_reload_interval,
   input  logic [pctb_pkg::INT_W-1:0]         req_step_size,
   input  logic                               req_count_down,
   input  logic [pctb_pkg::MODE_W-1:0]        req_compare_mode,
   input  logic [pctb_pkg::VAL_W-1:0]         req_threshold,
   input  logic                               req_run,
   input  logic [pctb_pkg::ID_W-1:0]          req_action_id,
   input  logic [pctb_pkg::ID_W-1:0]          req_owner_id,
   // Result channel
   input  logic                               rsp_valid,
   input  logic                               rsp_fired,
   input  logic [pctb_pkg::TIDX_W-1:0]        rsp_fired_index,
   input  logic [pctb_pkg::ID_W-1:0]          rsp_fired_action,
   input  logic [pctb_pkg::ID_W-1:0]          rsp_fired_owner,
   input  logic [pctb_pkg::VAL_W-1:0]         rsp_current_value,
   input  logic                               rsp_last,
   // Register channel
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [pctb_pkg::CFG_W-1:0]         csr_data,
   // Status toward the testbench top
   output int                                 fail_count,
   output int                                 open_results,
   output int                                 results_seen,
   output int                                 fires_seen
);

   import pctb_pkg::*;

   // One result of a tick
   typedef struct packed {
      logic              fired;
      logic [TIDX_W-1:0] index;
      logic [ID_W-1:0]   action;
      logic [ID_W-1:0]   owner;
      logic [VAL_W-1:0]  value;
      logic              last;
   } tick_result_type;

   timer_rec_type    bank [NUM_TIMERS];
   logic [CFG_W-1:0] slots_scanned;
   tick_result_type  tick_results_q [$];

   // Signed compare of a timer value against its threshold
   function automatic logic threshold_hit(timer_rec_type t);
      case (t.mode)
         CMP_EQ:  return $signed(t.value) == $signed(t.threshold);
         CMP_GE:  return $signed(t.value) >= $signed(t.threshold);
         CMP_LE:  return $signed(t.value) <= $signed(t.threshold);
         default: return 1'b0;
      endcase
   endfunction

   // Advance every scanned running timer by one tick and queue its results
   function automatic void advance_bank();
      int              limit;
      tick_result_type fire_list [$];
      tick_result_type r;
      limit = (slots_scanned > NUM_TIMERS) ? NUM_TIMERS : int'(slots_scanned);
      for (int i = 0; i < limit; i++) begin
         if (bank[i].run) begin
            bank[i].countdown = bank[i].countdown - INT_W'(1);
            if (bank[i].countdown == '0) begin
               bank[i].countdown = bank[i].interval;
               if (bank[i].dir_down)
                  bank[i].value = bank[i].value - {{(VAL_W-INT_W){1'b0}}, bank[i].step};
               else
                  bank[i].value = bank[i].value + {{(VAL_W-INT_W){1'b0}}, bank[i].step};
            end
            // slot still updates when the fire list is full
            if (threshold_hit(bank[i]) && fire_list.size() < RESULT_LIMIT) begin
               r.fired  = 1'b1;
               r.index  = TIDX_W'(i);
               r.action = bank[i].action;
               r.owner  = bank[i].owner;
               r.value  = bank[i].value;
               r.last   = 1'b0;
               fire_list.push_back(r);
            end
         end
      end
      // quiet tick: one empty result
      if (fire_list.size() == 0) begin
         r      = '0;
         r.last = 1'b1;
         fire_list.push_back(r);
      end else begin
         fire_list[fire_list.size()-1].last = 1'b1;
      end
      foreach (fire_list[k]) tick_results_q.push_back(fire_list[k]);
   endfunction

   function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                       logic [VAL_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Monitor: results first, then register writes, then new requests
   always @(posedge clock) begin : monitor
      tick_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) bank[i] = '0;
         slots_scanned = '0;
         tick_results_q.delete();
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (rsp_fired === 1'b1) fires_seen++;
            if (tick_results_q.size() == 0) begin
               $error("result with no expected result waiting (fired %0b index %0d)",
                      rsp_fired, rsp_fired_index);
               fail_count++;
            end else begin
               want = tick_results_q.pop_front();
               check_field("fired", VAL_W'(want.fired), VAL_W'(rsp_fired));
               check_field("fired_index", VAL_W'(want.index), VAL_W'(rsp_fired_index));
               check_field("fired_action", VAL_W'(want.action), VAL_W'(rsp_fired_action));
               check_field("fired_owner", VAL_W'(want.owner), VAL_W'(rsp_fired_owner));
               check_field("current_value", want.value, rsp_current_value);
               check_field("last", VAL_W'(want.last), VAL_W'(rsp_last));
            end
         end
         if (csr_valid && csr_ready)
            slots_scanned = csr_data;
         if (start && !busy) begin
            if (req_type == REQ_LOAD) begin
               if (req_timer_index < NUM_TIMERS) begin
                  bank[req_timer_index].value     = req_start_value;
                  bank[req_timer_index].interval  = req_reload_interval;
                  bank[req_timer_index].countdown = req_reload_interval;
                  bank[req_timer_index].step      = req_step_size;
                  bank[req_timer_index].dir_down  = req_count_down;
                  bank[req_timer_index].mode      = req_compare_mode;
                  bank[req_timer_index].threshold = req_threshold;
                  bank[req_timer_index].run       = req_run;
                  bank[req_timer_index].action    = req_action_id;
                  bank[req_timer_index].owner     = req_owner_id;
               end
            end else begin
               advance_bank();
            end
         end
      end
      open_results <= tick_results_q.size();
   end

endmodule

// ===== tb/prescaled_compare_timer_bank_core_tb.sv =====
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives loads and ticks into the timer bank under several slot-count
// settings, with random gaps between requests, and leaves prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prescaled_compare_timer_bank_core_tb;

   import pctb_pkg::*;

   localparam logic [MODE_W-1:0] CMP_NEVER   = 2'd3;
   localparam int                TICK_CYCLES = NUM_TIMERS + 2;
   localparam int                PHASE_ITEMS = 65;

   // One request as the testbench builds it
   typedef struct {
      logic              kind;
      logic [TIDX_W-1:0] idx;
      logic [VAL_W-1:0]  value;
      logic [INT_W-1:0]  interval;
      logic [INT_W-1:0]  step;
      logic              down;
      logic [MODE_W-1:0] mode;
      logic [VAL_W-1:0]  thr;
      logic              run;
      logic [ID_W-1:0]   act;
      logic [ID_W-1:0]   own;
   } timer_req_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic [TIDX_W-1:0]  req_timer_index;
   logic [VAL_W-1:0]   req_start_value;
   logic [INT_W-1:0]   req_reload_interval;
   logic [INT_W-1:0]   req_step_size;
   logic               req_count_down;
   logic [MODE_W-1:0]  req_compare_mode;
   logic [VAL_W-1:0]   req_threshold;
   logic               req_run;
   logic [ID_W-1:0]    req_action_id;
   logic [ID_W-1:0]    req_owner_id;
   logic               rsp_valid;
   logic               rsp_fired;
   logic [TIDX_W-1:0]  rsp_fired_index;
   logic [ID_W-1:0]    rsp_fired_action;
   logic [ID_W-1:0]    rsp_fired_owner;
   logic [VAL_W-1:0]   rsp_current_value;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data;

   int fail_count;
   int open_results;
   int results_seen;
   int fires_seen;
   int loads_sent;
   int ticks_sent;
   int settings_used;
   int calm_left;

   always #4 clock = ~clock;

   prescaled_compare_timer_bank_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_timer_index     (req_timer_index),
      .req_start_value     (req_start_value),
      .req_reload_interval (req_reload_interval),
      .req_step_size       (req_step_size),
      .req_count_down      (req_count_down),
      .req_compare_mode    (req_compare_mode),
      .req_threshold       (req_threshold),
      .req_run             (req_run),
      .req_action_id       (req_action_id),
      .req_owner_id        (req_owner_id),
      .rsp_valid           (rsp_valid),
      .rsp_fired           (rsp_fired),
      .rsp_fired_index     (rsp_fired_index),
      .rsp_fired_action    (rsp_fired_action),
      .rsp_fired_owner     (rsp_fired_owner),
      .rsp_current_value   (rsp_current_value),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   timer_bank_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_timer_index     (req_timer_index),
      .req_start_value     (req_start_value),
      .req_reload_interval (req_reload_interval),
      .req_step_size       (req_step_size),
      .req_count_down      (req_count_down),
      .req_compare_mode    (req_compare_mode),
      .req_threshold       (req_threshold),
      .req_run             (req_run),
      .req_action_id       (req_action_id),
      .req_owner_id        (req_owner_id),
      .rsp_valid           (rsp_valid),
      .rsp_fired           (rsp_fired),
      .rsp_fired_index     (rsp_fired_index),
      .rsp_fired_action    (rsp_fired_action),
      .rsp_fired_owner     (rsp_fired_owner),
      .rsp_current_value   (rsp_current_value),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .open_results        (open_results),
      .results_seen        (results_seen),
      .fires_seen          (fires_seen)
   );

   // Load request with every field given
   function automatic timer_req_type load_req(
      logic [TIDX_W-1:0] idx, logic [VAL_W-1:0] value, logic [INT_W-1:0] interval,
      logic [INT_W-1:0] step, logic down, logic [MODE_W-1:0] mode,
      logic [VAL_W-1:0] thr, logic run, logic [ID_W-1:0] act, logic [ID_W-1:0] own);
      timer_req_type r;
      r.kind     = REQ_LOAD;
      r.idx      = idx;
      r.value    = value;
      r.interval = interval;
      r.step     = step;
      r.down     = down;
      r.mode     = mode;
      r.thr      = thr;
      r.run      = run;
      r.act      = act;
      r.own      = own;
      return r;
   endfunction

   // Fully random load fields
   function automatic timer_req_type noise_req();
      return load_req(TIDX_W'($urandom), $urandom, INT_W'($urandom), INT_W'($urandom),
                      1'($urandom), MODE_W'($urandom), $urandom, 1'($urandom),
                      ID_W'($urandom), ID_W'($urandom));
   endfunction

   // Tick request; the unused fields carry junk the bank must ignore
   function automatic timer_req_type tick_req();
      timer_req_type r;
      r      = noise_req();
      r.kind = REQ_TICK;
      return r;
   endfunction

   // Mostly well-formed loads near the compare point, some pure noise
   function automatic timer_req_type random_load();
      timer_req_type r;
      logic [VAL_W-1:0] base;
      if ($urandom_range(0, 4) == 0)
         return noise_req();
      case ($urandom_range(0, 2))
         0:       base = $urandom_range(0, 200) - 100;
         1:       base = 32'h7FFF_FF00 + $urandom_range(0, 255);
         default: base = 32'h8000_0000 + $urandom_range(0, 255);
      endcase
      r = load_req(TIDX_W'($urandom_range(0, NUM_TIMERS - 1)), base,
                   INT_W'($urandom_range(1, 4)), INT_W'($urandom_range(0, 40)),
                   1'($urandom), MODE_W'($urandom_range(0, 3)),
                   base + ($urandom_range(0, 120) - 60), $urandom_range(0, 7) != 0,
                   ID_W'($urandom), ID_W'($urandom));
      return r;
   endfunction

   // Present one request and hold it until the bank takes it
   task automatic send_request(timer_req_type r);
      int gap;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 20);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_type            <= r.kind;
      req_timer_index     <= r.idx;
      req_start_value     <= r.value;
      req_reload_interval <= r.interval;
      req_step_size       <= r.step;
      req_count_down      <= r.down;
      req_compare_mode    <= r.mode;
      req_threshold       <= r.thr;
      req_run             <= r.run;
      req_action_id       <= r.act;
      req_owner_id        <= r.own;
      do @(posedge clock); while (busy);
      if (r.kind == REQ_LOAD) loads_sent++;
      else ticks_sent++;
   endtask

   // Wait until every expected result is in and the bank has gone quiet
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (open_results != 0 || busy);
      repeat (TICK_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(logic [CFG_W-1:0] count);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_requests(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 6) send_request(tick_req());
         else send_request(random_load());
      end
   endtask

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      logic [CFG_W-1:0] settings [7];
      settings = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16, 5'd16};
      settings[5] = CFG_W'($urandom_range(0, 31));
      reset               <= 1'b1;
      start               <= 1'b0;
      req_type            <= REQ_TICK;
      req_timer_index     <= '0;
      req_start_value     <= '0;
      req_reload_interval <= '0;
      req_step_size       <= '0;
      req_count_down      <= 1'b0;
      req_compare_mode    <= CMP_EQ;
      req_threshold       <= '0;
      req_run             <= 1'b0;
      req_action_id       <= '0;
      req_owner_id        <= '0;
      csr_valid           <= 1'b0;
      csr_data            <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty bank, value wrap both ways, every compare mode,
      // zero interval, stopped slot, always-firing slot
      write_slot_count(5'd16);
      send_request(tick_req());
      send_request(load_req(4'd0, 32'h7FFF_FFFF, 16'd1, 16'd1, 1'b0, CMP_EQ,
                            32'h8000_0000, 1'b1, 16'hFFFF, 16'h0000));
      send_request(load_req(4'd15, 32'h8000_0000, 16'd1, 16'hFFFF, 1'b1, CMP_GE,
                            32'h7FFF_0001, 1'b1, 16'h0000, 16'hFFFF));
      send_request(load_req(4'd1, 32'd5, 16'd2, 16'd3, 1'b0, CMP_LE,
                            32'd10, 1'b1, 16'h1234, 16'h4321));
      send_request(load_req(4'd2, 32'd0, 16'd1, 16'd0, 1'b0, CMP_NEVER,
                            32'd0, 1'b1, 16'hAAAA, 16'h5555));
      send_request(load_req(4'd3, 32'd0, 16'd0, 16'hFFFF, 1'b1, CMP_GE,
                            32'hFFFF_FFFF, 1'b1, 16'h5555, 16'hAAAA));
      send_request(load_req(4'd4, -32'sd5, 16'd1, 16'd1, 1'b0, CMP_GE,
                            32'h8000_0000, 1'b0, 16'h0F0F, 16'hF0F0));
      repeat (4) send_request(tick_req());
      send_request(load_req(4'd0, 32'd0, 16'd1, 16'd0, 1'b0, CMP_EQ,
                            32'd0, 1'b0, 16'd0, 16'd0));
      send_request(load_req(4'd5, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b0, CMP_LE,
                            32'h7FFF_FFFF, 1'b1, 16'hBEEF, 16'h0001));
      repeat (2) send_request(tick_req());

      // Random phases, one slot-count setting each
      foreach (settings[p]) begin
         settle();
         write_slot_count(settings[p]);
         // full bank firing at once under the saturated setting
         if (settings[p] == 5'd31) begin
            for (int s = 0; s < NUM_TIMERS; s++)
               send_request(load_req(TIDX_W'(s), $urandom, INT_W'($urandom_range(1, 3)),
                                     INT_W'($urandom), 1'($urandom), CMP_GE,
                                     32'h8000_0000, 1'b1, ID_W'($urandom),
                                     ID_W'($urandom)));
            repeat (3) send_request(tick_req());
         end
         random_requests(PHASE_ITEMS);
      end

      settle();
      $display("Sent %0d loads and %0d ticks across %0d slot-count settings.",
               loads_sent, ticks_sent, settings_used);
      $display("Checked %0d results, %0d of them timer fires.", results_seen, fires_seen);
      if (fail_count == 0 && open_results == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
